// ===== src/ctcc_pkg.sv =====
`timescale 1ns / 1ps

package ctcc_pkg;

   localparam int CHANNELS = 8;
   localparam int TAPS     = 3;

   // fixed field widths of the transactions
   localparam int OP_W       = 2;
   localparam int FIELD_CH_W = 3;
   localparam int FIELD_TP_W = 2;
   localparam int VALUE_W    = 16;

   localparam int CH_W    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int TAP_W   = (TAPS > 1) ? $clog2(TAPS) : 1;
   localparam int W_DEPTH = CHANNELS * CHANNELS * TAPS;
   localparam int H_DEPTH = CHANNELS * TAPS;
   localparam int WADDR_W = (W_DEPTH > 1) ? $clog2(W_DEPTH) : 1;
   localparam int HADDR_W = (H_DEPTH > 1) ? $clog2(H_DEPTH) : 1;

   localparam int COEF_FRAC = 12;
   localparam int PROD_W    = 2 * VALUE_W;
   localparam int ACC_W     = PROD_W + 1 + $clog2(H_DEPTH + 1);

   typedef enum logic [OP_W-1:0] {
      OP_LOAD_WEIGHT = 2'd0,
      OP_LOAD_BIAS   = 2'd1,
      OP_SAMPLE      = 2'd2
   } op_type;

   typedef struct packed {
      logic issue;
      logic use_tap;
      logic clear;
   } mac_ctrl_type;

   function automatic logic [TAP_W-1:0] tap_next(input logic [TAP_W-1:0] x);
      tap_next = (int'(x) == TAPS - 1) ? '0 : x + 1'b1;
   endfunction

endpackage

// ===== src/ctcc_if.sv =====
`timescale 1ns / 1ps

interface ctcc_req_if;
   import ctcc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           opcode;
   logic [FIELD_CH_W-1:0]     out_channel;
   logic [FIELD_CH_W-1:0]     in_channel;
   logic [FIELD_TP_W-1:0]     tap;
   logic signed [VALUE_W-1:0] value;
   logic                      position_start;

   modport source (output valid, opcode, out_channel, in_channel, tap, value, position_start,
                   input ready);
   modport sink   (input valid, opcode, out_channel, in_channel, tap, value, position_start,
                   output ready);
endinterface

interface ctcc_rsp_if;
   import ctcc_pkg::*;
   logic                      valid;
   logic                      ready;
   logic [FIELD_CH_W-1:0]     result_channel;
   logic signed [VALUE_W-1:0] result_value;
   logic                      last;

   modport source (output valid, result_channel, result_value, last, input ready);
   modport sink   (input valid, result_channel, result_value, last, output ready);
endinterface

// ===== src/ctcc_coef_mem.sv =====
`timescale 1ns / 1ps

module ctcc_coef_mem (
   input  logic                               clock,
   input  logic                               w_we,
   input  logic [ctcc_pkg::WADDR_W-1:0]       w_waddr,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] w_wdata,
   input  logic [ctcc_pkg::WADDR_W-1:0]       w_raddr,
   output logic signed [ctcc_pkg::VALUE_W-1:0] w_rdata,
   input  logic                               b_we,
   input  logic [ctcc_pkg::CH_W-1:0]          b_waddr,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] b_wdata,
   input  logic [ctcc_pkg::CH_W-1:0]          b_raddr,
   output logic signed [ctcc_pkg::VALUE_W-1:0] b_rdata
);
   import ctcc_pkg::*;

   logic signed [VALUE_W-1:0] weight_mem [W_DEPTH];
   logic signed [VALUE_W-1:0] bias_mem [CHANNELS];
   logic signed [VALUE_W-1:0] w_rdata_ff;
   logic signed [VALUE_W-1:0] b_rdata_ff;

   always_ff @(posedge clock) begin
      if (w_we) begin
         weight_mem[w_waddr] <= w_wdata;
      end
      w_rdata_ff <= weight_mem[w_raddr];
   end

   always_ff @(posedge clock) begin
      if (b_we) begin
         bias_mem[b_waddr] <= b_wdata;
      end
      b_rdata_ff <= bias_mem[b_raddr];
   end

   assign w_rdata = w_rdata_ff;
   assign b_rdata = b_rdata_ff;

endmodule

// ===== src/ctcc_hist_mem.sv =====
`timescale 1ns / 1ps

module ctcc_hist_mem (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               we,
   input  logic [ctcc_pkg::HADDR_W-1:0]       waddr,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] wdata,
   input  logic [ctcc_pkg::HADDR_W-1:0]       raddr,
   output logic signed [ctcc_pkg::VALUE_W-1:0] rdata
);
   import ctcc_pkg::*;

   logic signed [VALUE_W-1:0] hist_mem [H_DEPTH];
   logic [H_DEPTH-1:0]        valid_ff;
   logic signed [VALUE_W-1:0] rdata_ff;
   logic                      rvalid_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         hist_mem[waddr] <= wdata;
      end
      rdata_ff <= hist_mem[raddr];
   end

   // never-written slots read as zero
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         if (we) begin
            valid_ff[waddr] <= 1'b1;
         end
         rvalid_ff <= valid_ff[raddr];
      end
   end

   assign rdata = rvalid_ff ? rdata_ff : '0;

endmodule

// ===== src/ctcc_mac.sv =====
`timescale 1ns / 1ps

module ctcc_mac (
   input  logic                               clock,
   input  logic                               reset,
   input  ctcc_pkg::mac_ctrl_type             ctrl,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] sample,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] weight,
   input  logic signed [ctcc_pkg::VALUE_W-1:0] bias,
   output logic signed [ctcc_pkg::VALUE_W-1:0] result
);
   import ctcc_pkg::*;

   localparam int Q_W = ACC_W - COEF_FRAC;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(32767);
   localparam logic signed [Q_W-1:0] Q_MIN = Q_W'(-32768);

   logic                     issue_ff;
   logic                     use_ff;
   logic                     prod_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [ACC_W-1:0]  bias_ext;
   logic signed [ACC_W-1:0]  sum;
   logic signed [Q_W-1:0]    q;

   always_ff @(posedge clock) begin
      if (reset) begin
         issue_ff      <= 1'b0;
         use_ff        <= 1'b0;
         prod_valid_ff <= 1'b0;
         acc_ff        <= '0;
      end else begin
         issue_ff      <= ctrl.issue;
         use_ff        <= ctrl.use_tap;
         prod_valid_ff <= issue_ff;
         if (ctrl.clear) begin
            acc_ff <= '0;
         end else if (prod_valid_ff) begin
            acc_ff <= acc_ff + {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
         end
      end
   end

   // taps older than the position start contribute nothing
   always_ff @(posedge clock) begin
      if (use_ff) begin
         prod_ff <= sample * weight;
      end else begin
         prod_ff <= '0;
      end
   end

   always_comb begin
      bias_ext = {{(ACC_W-VALUE_W-COEF_FRAC){bias[VALUE_W-1]}}, bias, {COEF_FRAC{1'b0}}};
      sum      = acc_ff + bias_ext;
      q        = sum[ACC_W-1:COEF_FRAC];
      if (q > Q_MAX) begin
         result = VALUE_W'(Q_MAX);
      end else if (q < Q_MIN) begin
         result = VALUE_W'(Q_MIN);
      end else begin
         result = q[VALUE_W-1:0];
      end
   end

endmodule

// ===== src/causal_temporal_channel_conv_core.sv =====
`timescale 1ns / 1ps

// channel   port      direction  contents
// req       req_bus   in         opcode, out_channel, in_channel, tap, value, position_start
// rsp       rsp_bus   out        result_channel, result_value, last
//
// loads and samples of channels below the last are accepted whenever the core is idle
// the last-channel sample runs the shared multiply-accumulate over the weight and history
// memories, with one memory read pair per product, and waits whenever rsp is held off
// reset is synchronous; history reads as zero until written, weights and bias are not cleared
// req is held off while a time step is being computed

module causal_temporal_channel_conv_core (
   input  logic        clock,
   input  logic        reset,
   ctcc_req_if.sink    req_bus,
   ctcc_rsp_if.source  rsp_bus
);
   import ctcc_pkg::*;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DRAIN, ST_EMIT} state_type;

   state_type                 state_ff;
   logic [CH_W-1:0]           co_ff;
   logic [CH_W-1:0]           ci_ff;
   logic [TAP_W-1:0]          k_ff;
   logic [TAP_W-1:0]          slot_ff;
   logic [TAP_W-1:0]          slot_start_ff;
   logic [TAP_W-1:0]          steps_cap_ff;
   logic [WADDR_W-1:0]        waddr_ff;
   logic                      drain_ff;
   logic [TAP_W-1:0]          head_ff;
   logic [TAP_W-1:0]          steps_ff;
   logic                      rsp_valid_ff;
   logic [FIELD_CH_W-1:0]     rsp_channel_ff;
   logic signed [VALUE_W-1:0] rsp_value_ff;
   logic                      rsp_last_ff;

   logic                      req_accept;
   logic                      w_we;
   logic                      b_we;
   logic                      s_we;
   logic                      step_done;
   logic [TAP_W-1:0]          steps_now;
   logic                      emit_go;
   logic                      co_last;
   logic [WADDR_W-1:0]        w_waddr;
   logic [HADDR_W-1:0]        h_waddr;
   logic [HADDR_W-1:0]        h_raddr;
   logic signed [VALUE_W-1:0] w_rdata;
   logic signed [VALUE_W-1:0] b_rdata;
   logic signed [VALUE_W-1:0] h_rdata;
   logic signed [VALUE_W-1:0] mac_result;
   mac_ctrl_type              mac_ctrl;

   assign req_bus.ready = (state_ff == ST_IDLE);
   assign req_accept    = req_bus.valid && req_bus.ready;

   always_comb begin
      w_we = req_accept && (req_bus.opcode == OP_LOAD_WEIGHT)
             && (int'(req_bus.out_channel) < CHANNELS)
             && (int'(req_bus.in_channel) < CHANNELS)
             && (int'(req_bus.tap) < TAPS);
      b_we = req_accept && (req_bus.opcode == OP_LOAD_BIAS)
             && (int'(req_bus.out_channel) < CHANNELS);
      s_we = req_accept && (req_bus.opcode == OP_SAMPLE)
             && (int'(req_bus.in_channel) < CHANNELS);
      step_done = s_we && (int'(req_bus.in_channel) == CHANNELS - 1);
      steps_now = req_bus.position_start ? '0 : steps_ff;
      // weight layout: (out channel, tap, in channel) so reads walk it linearly
      w_waddr = WADDR_W'((int'(req_bus.out_channel) * TAPS + int'(req_bus.tap)) * CHANNELS
                         + int'(req_bus.in_channel));
      h_waddr = HADDR_W'(int'(head_ff) * CHANNELS + int'(req_bus.in_channel));
      h_raddr = HADDR_W'(int'(slot_ff) * CHANNELS + int'(ci_ff));
      co_last = (int'(co_ff) == CHANNELS - 1);
      emit_go = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_bus.ready);
      mac_ctrl.issue   = (state_ff == ST_RUN);
      mac_ctrl.use_tap = (int'(k_ff) + int'(steps_cap_ff) >= TAPS - 1);
      mac_ctrl.clear   = emit_go;
   end

   ctcc_coef_mem u_coef (
      .clock   (clock),
      .w_we    (w_we),
      .w_waddr (w_waddr),
      .w_wdata (req_bus.value),
      .w_raddr (waddr_ff),
      .w_rdata (w_rdata),
      .b_we    (b_we),
      .b_waddr (CH_W'(req_bus.out_channel)),
      .b_wdata (req_bus.value),
      .b_raddr (co_ff),
      .b_rdata (b_rdata)
   );

   ctcc_hist_mem u_hist (
      .clock (clock),
      .reset (reset),
      .we    (s_we),
      .waddr (h_waddr),
      .wdata (req_bus.value),
      .raddr (h_raddr),
      .rdata (h_rdata)
   );

   ctcc_mac u_mac (
      .clock  (clock),
      .reset  (reset),
      .ctrl   (mac_ctrl),
      .sample (h_rdata),
      .weight (w_rdata),
      .bias   (b_rdata),
      .result (mac_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         co_ff         <= '0;
         ci_ff         <= '0;
         k_ff          <= '0;
         slot_ff       <= '0;
         slot_start_ff <= '0;
         steps_cap_ff  <= '0;
         waddr_ff      <= '0;
         drain_ff      <= 1'b0;
         head_ff       <= '0;
         steps_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (emit_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (s_we) begin
                  steps_ff <= steps_now;
                  if (step_done) begin
                     slot_start_ff <= tap_next(head_ff);
                     slot_ff       <= tap_next(head_ff);
                     steps_cap_ff  <= steps_now;
                     head_ff       <= tap_next(head_ff);
                     if (int'(steps_now) < TAPS - 1) begin
                        steps_ff <= steps_now + 1'b1;
                     end
                     co_ff    <= '0;
                     ci_ff    <= '0;
                     k_ff     <= '0;
                     waddr_ff <= '0;
                     state_ff <= ST_RUN;
                  end
               end
            end
            ST_RUN: begin
               waddr_ff <= waddr_ff + 1'b1;
               if (int'(ci_ff) == CHANNELS - 1) begin
                  ci_ff   <= '0;
                  slot_ff <= tap_next(slot_ff);
                  if (int'(k_ff) == TAPS - 1) begin
                     k_ff     <= '0;
                     drain_ff <= 1'b0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end else begin
                  ci_ff <= ci_ff + 1'b1;
               end
            end
            ST_DRAIN: begin
               drain_ff <= 1'b1;
               if (drain_ff) begin
                  state_ff <= ST_EMIT;
               end
            end
            ST_EMIT: begin
               if (emit_go) begin
                  rsp_channel_ff <= FIELD_CH_W'(co_ff);
                  rsp_value_ff   <= mac_result;
                  rsp_last_ff    <= co_last;
                  slot_ff        <= slot_start_ff;
                  if (co_last) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     co_ff    <= co_ff + 1'b1;
                     state_ff <= ST_RUN;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_channel = rsp_channel_ff;
   assign rsp_bus.result_value   = rsp_value_ff;
   assign rsp_bus.last           = rsp_last_ff;

endmodule

// ===== tb/tb_causal_temporal_channel_conv_core.sv =====
`timescale 1ns / 1ps

module tb_causal_temporal_channel_conv_core;
   import ctcc_pkg::*;

   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam int RANDOM_ITEMS = 256;
   localparam int IDLE_PCT     = 37;
   localparam int STALL_LIMIT  = 5000;
   localparam int DRAIN_CYCLES = 300;
   localparam longint SAT_HI   = 2 ** (VALUE_W - 1) - 1;
   localparam longint SAT_LO   = -(2 ** (VALUE_W - 1));

   typedef struct packed {
      logic [OP_W-1:0]       opcode;
      logic [FIELD_CH_W-1:0] out_channel;
      logic [FIELD_CH_W-1:0] in_channel;
      logic [FIELD_TP_W-1:0] tap;
      logic [VALUE_W-1:0]    value;
      logic                  position_start;
   } req_item_t;

   typedef struct packed {
      logic [FIELD_CH_W-1:0] channel;
      logic [VALUE_W-1:0]    value;
      logic                  last;
   } conv_result_t;

   typedef struct packed {
      req_item_t                        item;
      logic                             chk;
      logic [CHANNELS-1:0][VALUE_W-1:0] want;
   } dir_row_t;

   logic clock;
   logic reset;

   ctcc_req_if req_bus();
   ctcc_rsp_if rsp_bus();

   causal_temporal_channel_conv_core dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   // shadow state of the convolution
   logic signed [VALUE_W-1:0] weight_mem [W_DEPTH];
   logic signed [VALUE_W-1:0] bias_mem   [CHANNELS];
   logic signed [VALUE_W-1:0] history    [H_DEPTH];
   int                        hist_head;
   int                        hist_seen;

   conv_result_t conv_results_q [$];
   int           mismatches;
   int           work_items;
   int           idle_cycles;
   logic         steady;

   // want is packed channel 7 down to channel 0
   dir_row_t directed_rows [24] = '{
      '{'{OP_LOAD_BIAS,   3'd0, 3'd0, 2'd0, 16'h7fff, 1'b0}, 1'b0, '0},
      '{'{OP_LOAD_BIAS,   3'd7, 3'd0, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_LOAD_WEIGHT, 3'd0, 3'd0, 2'd3, 16'h7fff, 1'b0}, 1'b0, '0},
      '{'{OP_UNUSED,      3'd7, 3'd7, 2'd3, 16'hffff, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd0, 2'd0, 16'h7fff, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd1, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd2, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd3, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd4, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd5, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd6, 2'd0, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd7, 2'd0, 16'h7fff, 1'b0}, 1'b1,
        {16'h8000, {6{16'h0000}}, 16'h7fff}},
      '{'{OP_LOAD_WEIGHT, 3'd1, 3'd0, 2'd2, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_LOAD_WEIGHT, 3'd1, 3'd7, 2'd2, 16'h7fff, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd0, 2'd0, 16'h8000, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd7, 2'd0, 16'h8000, 1'b0}, 1'b1,
        {16'h8000, {5{16'h0000}}, 16'h0008, 16'h7fff}},
      '{'{OP_LOAD_WEIGHT, 3'd2, 3'd0, 2'd2, 16'h8000, 1'b0}, 1'b0, '0},
      '{'{OP_LOAD_WEIGHT, 3'd3, 3'd0, 2'd2, 16'h7fff, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd0, 2'd0, 16'h8000, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd7, 2'd0, 16'h0000, 1'b0}, 1'b1,
        {16'h8000, {3{16'h0000}}, 16'h8000, 16'h7fff, 16'h7fff, 16'h7fff}},
      '{'{OP_LOAD_WEIGHT, 3'd4, 3'd3, 2'd0, 16'h1000, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd7, 2'd0, 16'h0100, 1'b0}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd3, 2'd0, 16'hffff, 1'b1}, 1'b0, '0},
      '{'{OP_SAMPLE,      3'd0, 3'd7, 2'd0, 16'hfffe, 1'b0}, 1'b0, '0}
   };

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      mismatches++;
   endtask

   // updates the shadow state; a completed step queues one result per output channel
   function automatic void conv_predict(input req_item_t it, input logic chk,
                                        input logic [CHANNELS-1:0][VALUE_W-1:0] want);
      longint       acc;
      int           age;
      int           slot;
      conv_result_t r;
      case (it.opcode)
         OP_LOAD_WEIGHT: begin
            if (int'(it.out_channel) < CHANNELS && int'(it.in_channel) < CHANNELS &&
                int'(it.tap) < TAPS)
               weight_mem[(int'(it.out_channel) * CHANNELS + int'(it.in_channel)) * TAPS +
                          int'(it.tap)] = it.value;
         end
         OP_LOAD_BIAS: begin
            if (int'(it.out_channel) < CHANNELS) bias_mem[it.out_channel] = it.value;
         end
         OP_SAMPLE: begin
            if (int'(it.in_channel) < CHANNELS) begin
               if (it.position_start) hist_seen = 0;
               history[hist_head * CHANNELS + int'(it.in_channel)] = it.value;
               if (int'(it.in_channel) == CHANNELS - 1) begin
                  for (int co = 0; co < CHANNELS; co++) begin
                     acc = longint'(bias_mem[co]) <<< COEF_FRAC;
                     for (int k = 0; k < TAPS; k++) begin
                        age = TAPS - 1 - k;
                        if (age <= hist_seen) begin
                           slot = (hist_head + TAPS - age) % TAPS;
                           for (int ci = 0; ci < CHANNELS; ci++)
                              acc += longint'(history[slot * CHANNELS + ci]) *
                                     longint'(weight_mem[(co * CHANNELS + ci) * TAPS + k]);
                        end
                     end
                     acc = acc >>> COEF_FRAC;
                     if (acc > SAT_HI) acc = SAT_HI;
                     else if (acc < SAT_LO) acc = SAT_LO;
                     r.channel = co[FIELD_CH_W-1:0];
                     r.value   = chk ? want[co] : VALUE_W'(acc);
                     r.last    = (co == CHANNELS - 1);
                     conv_results_q.push_back(r);
                  end
                  hist_head = (hist_head + 1) % TAPS;
                  if (hist_seen < TAPS - 1) hist_seen++;
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(input req_item_t it, input logic chk,
                            input logic [CHANNELS-1:0][VALUE_W-1:0] want);
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid          <= 1'b1;
      req_bus.opcode         <= it.opcode;
      req_bus.out_channel    <= it.out_channel;
      req_bus.in_channel     <= it.in_channel;
      req_bus.tap            <= it.tap;
      req_bus.value          <= it.value;
      req_bus.position_start <= it.position_start;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      conv_predict(it, chk, want);
      if (!(it.opcode == OP_UNUSED || (it.opcode == OP_LOAD_WEIGHT && int'(it.tap) >= TAPS)))
         work_items++;
   endtask

   function automatic logic [VALUE_W-1:0] rand_word();
      case ($urandom_range(7))
         0:       return 16'h7fff;
         1:       return 16'h8000;
         2, 3:    return VALUE_W'($urandom_range(1023)) - VALUE_W'(512);
         default: return VALUE_W'($urandom);
      endcase
   endfunction

   function automatic req_item_t rand_sample(input int ch, input logic start);
      req_item_t it;
      it.opcode         = OP_SAMPLE;
      it.out_channel    = FIELD_CH_W'($urandom);
      it.in_channel     = FIELD_CH_W'(ch);
      it.tap            = FIELD_TP_W'($urandom);
      it.value          = rand_word();
      it.position_start = start;
      return it;
   endfunction

   // transaction response checker
   always @(posedge clock) begin : rsp_check
      conv_result_t exp_r;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (conv_results_q.size() == 0) begin
               report_mismatch("unexpected result, channel", int'(rsp_bus.result_channel), -1);
            end else begin
               exp_r = conv_results_q.pop_front();
               if (rsp_bus.result_channel !== exp_r.channel)
                  report_mismatch("result_channel", int'(rsp_bus.result_channel),
                                  int'(exp_r.channel));
               if (rsp_bus.result_value !== exp_r.value)
                  report_mismatch("result_value", int'(rsp_bus.result_value),
                                  int'($signed(exp_r.value)));
               if (rsp_bus.last !== exp_r.last)
                  report_mismatch("last", int'(rsp_bus.last), int'(exp_r.last));
            end
         end
      end
   end

   // watchdog on cycles without any transaction
   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      req_item_t it;
      int        base;
      int        n;
      logic      paused;
      logic      start;

      reset                  = 1'b1;
      steady                 = 1'b0;
      mismatches             = 0;
      work_items             = 0;
      paused                 = 1'b0;
      hist_head              = 0;
      hist_seen              = 0;
      req_bus.valid          = 1'b0;
      req_bus.opcode         = OP_LOAD_WEIGHT;
      req_bus.out_channel    = '0;
      req_bus.in_channel     = '0;
      req_bus.tap            = '0;
      req_bus.value          = '0;
      req_bus.position_start = 1'b0;
      for (int i = 0; i < H_DEPTH; i++) history[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // clear every weight and bias so no store entry is read before it is written
      for (int oc = 0; oc < CHANNELS; oc++) begin
         for (int ic = 0; ic < CHANNELS; ic++)
            for (int tp = 0; tp < TAPS; tp++)
               send_item('{OP_LOAD_WEIGHT, FIELD_CH_W'(oc), FIELD_CH_W'(ic),
                           FIELD_TP_W'(tp), '0, 1'b0}, 1'b0, '0);
         send_item('{OP_LOAD_BIAS, FIELD_CH_W'(oc), '0, '0, '0, 1'b0}, 1'b0, '0);
      end

      foreach (directed_rows[i])
         send_item(directed_rows[i].item, directed_rows[i].chk, directed_rows[i].want);

      base = work_items;
      while (work_items < base + RANDOM_ITEMS) begin
         steady = (work_items >= base + 128) && (work_items < base + 208);
         if (!paused && work_items >= base + 96) begin
            paused = 1'b1;
            req_bus.valid <= 1'b0;
            do @(posedge clock); while (conv_results_q.size() != 0);
         end
         n = $urandom_range(99);
         if (n < 12) begin
            it = '{OP_LOAD_WEIGHT, FIELD_CH_W'($urandom), FIELD_CH_W'($urandom),
                   FIELD_TP_W'($urandom), rand_word(), 1'($urandom)};
            send_item(it, 1'b0, '0);
         end else if (n < 16) begin
            it = '{OP_LOAD_BIAS, FIELD_CH_W'($urandom), FIELD_CH_W'($urandom),
                   FIELD_TP_W'($urandom), rand_word(), 1'($urandom)};
            send_item(it, 1'b0, '0);
         end else if (n < 19) begin
            it = '{OP_UNUSED, FIELD_CH_W'($urandom), FIELD_CH_W'($urandom),
                   FIELD_TP_W'($urandom), rand_word(), 1'($urandom)};
            send_item(it, 1'b0, '0);
         end else if (n < 25) begin
            // broken step: a few samples in any channel order
            repeat ($urandom_range(1, 4))
               send_item(rand_sample($urandom_range(CHANNELS - 1), $urandom_range(3) == 0),
                         1'b0, '0);
         end else begin
            start = ($urandom_range(4) == 0);
            for (int ch = 0; ch < CHANNELS; ch++)
               send_item(rand_sample(ch, (ch == 0) ? start : ($urandom_range(31) == 0)),
                         1'b0, '0);
         end
      end
      steady = 1'b0;
      req_bus.valid <= 1'b0;

      while (conv_results_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0 && conv_results_q.size() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
